// ----- rtl/core/sdce_pkg.sv -----
// Shared types, codes and CRC7 helper for the SD SPI command engine.
package sdce_pkg;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_DESEL     = 4'd1,
        PH_SEL       = 4'd2,
        PH_READY1    = 4'd3,
        PH_FAILDESEL = 4'd4,
        PH_READY2    = 4'd5,
        PH_FRAME     = 4'd6,
        PH_STUFF     = 4'd7,
        PH_RESP      = 4'd8,
        PH_APPRESP   = 4'd9,
        PH_APPDESEL  = 4'd10
    } t_phase;

    // input item kinds
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_RX    = 1'b1;

    // result item kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] ST_OK              = 2'd0;
    localparam logic [1:0] ST_NOT_READY       = 2'd1;
    localparam logic [1:0] ST_PREFIX_REJECTED = 2'd2;
    localparam logic [1:0] ST_NO_RESPONSE     = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_READY_LIMIT = 2'd0;
    localparam logic [1:0] REG_RESP_LIMIT  = 2'd1;
    localparam logic [1:0] REG_APP_LIMIT   = 2'd2;

    localparam logic [9:0] READY_LIMIT_RST = 10'd500;
    localparam logic [7:0] RESP_LIMIT_RST  = 8'd200;
    localparam logic [7:0] APP_LIMIT_RST   = 8'd10;

    localparam logic [7:0] DUMMY_BYTE     = 8'hFF;
    localparam logic [7:0] CRC_BYTE_CMD0  = 8'h95;
    localparam logic [7:0] CRC_BYTE_CMD8  = 8'h87;
    localparam logic [6:0] CRC7_POLY      = 7'h09;
    localparam logic [5:0] APP_CMD_INDEX  = 6'd55;
    localparam logic [5:0] STOP_CMD_INDEX = 6'd12;
    localparam logic [5:0] GO_IDLE_INDEX  = 6'd0;
    localparam logic [5:0] IF_COND_INDEX  = 6'd8;
    localparam logic [2:0] CRC_POS        = 3'd5;

    typedef struct packed {
        logic        command;
        logic [5:0]  cmd_index;
        logic        app_command;
        logic [31:0] argument;
        logic [7:0]  rx_byte;
    } t_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       card_select;
        logic [7:0] response;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        logic [9:0] ready_poll_limit;
        logic [7:0] response_poll_limit;
        logic [7:0] app_response_limit;
    } t_cfg;

    // Shift one byte, MSB first, through the CRC7 register.
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] data);
        logic [6:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[6] ^ data[i];
            c  = {c[5:0], 1'b0};
            if (fb) begin
                c = c ^ CRC7_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/sdce_ctrl.sv -----
// Command sequencer: phase state machine, frame builder and poll counting.
module sdce_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  sdce_pkg::t_item  i_item,
    input  sdce_pkg::t_cfg   i_cfg,
    output logic             o_emit,
    output sdce_pkg::t_result o_result
);
    import sdce_pkg::*;

    t_phase      r_phase, n_phase;
    logic [9:0]  r_poll, n_poll;
    logic [2:0]  r_fidx, n_fidx;
    logic [6:0]  r_crc, n_crc;
    logic [5:0]  r_held_idx, n_held_idx;
    logic [31:0] r_held_arg, n_held_arg;
    logic        r_prefix, n_prefix;

    logic [9:0]  poll_inc;
    logic [9:0]  ready_lim;
    logic [9:0]  resp_lim;
    logic [9:0]  app_lim;
    logic [2:0]  next_pos;
    logic [7:0]  fbyte;

    // Byte at position pos of the frame; CMD55 prefix uses a zero argument.
    function automatic logic [7:0] frame_byte(input logic [2:0] pos, input logic prefix,
                                              input logic [5:0] idx, input logic [31:0] arg,
                                              input logic [6:0] crc);
        logic [5:0]  fi;
        logic [31:0] fa;
        logic [7:0]  b;
        fi = prefix ? APP_CMD_INDEX : idx;
        fa = prefix ? 32'd0 : arg;
        unique case (pos)
            3'd0:    b = {2'b01, fi};
            3'd1:    b = fa[31:24];
            3'd2:    b = fa[23:16];
            3'd3:    b = fa[15:8];
            3'd4:    b = fa[7:0];
            default: begin
                if (!prefix && idx == GO_IDLE_INDEX) begin
                    b = CRC_BYTE_CMD0;
                end else if (!prefix && idx == IF_COND_INDEX) begin
                    b = CRC_BYTE_CMD8;
                end else begin
                    b = {crc, 1'b1};
                end
            end
        endcase
        return b;
    endfunction

    assign poll_inc  = r_poll + 10'd1;
    // a zero limit behaves as one
    assign ready_lim = (i_cfg.ready_poll_limit == 10'd0) ? 10'd1 : i_cfg.ready_poll_limit;
    assign resp_lim  = (i_cfg.response_poll_limit == 8'd0) ? 10'd1
                                                            : {2'b00, i_cfg.response_poll_limit};
    assign app_lim   = (i_cfg.app_response_limit == 8'd0) ? 10'd1
                                                           : {2'b00, i_cfg.app_response_limit};
    assign next_pos  = r_fidx + 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_poll     <= '0;
            r_fidx     <= '0;
            r_crc      <= '0;
            r_held_idx <= '0;
            r_held_arg <= '0;
            r_prefix   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_poll     <= n_poll;
            r_fidx     <= n_fidx;
            r_crc      <= n_crc;
            r_held_idx <= n_held_idx;
            r_held_arg <= n_held_arg;
            r_prefix   <= n_prefix;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_poll     = r_poll;
        n_fidx     = r_fidx;
        n_crc      = r_crc;
        n_held_idx = r_held_idx;
        n_held_arg = r_held_arg;
        n_prefix   = r_prefix;
        fbyte      = '0;
        o_emit     = 1'b0;
        o_result   = '{kind: KIND_TX, tx_byte: DUMMY_BYTE, card_select: 1'b1,
                       response: 8'h00, status: ST_OK};
        if (i_fire) begin
            if (i_item.command == CMD_START) begin
                n_held_idx           = i_item.cmd_index;
                n_prefix             = i_item.app_command;
                n_held_arg           = i_item.argument;
                n_poll               = '0;
                n_fidx               = '0;
                n_crc                = '0;
                n_phase              = PH_DESEL;
                o_emit               = 1'b1;
                o_result.card_select = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_DESEL: begin
                        n_phase = PH_SEL;
                        o_emit  = 1'b1;
                    end
                    PH_SEL: begin
                        n_poll  = '0;
                        n_phase = PH_READY1;
                        o_emit  = 1'b1;
                    end
                    PH_READY1, PH_READY2: begin
                        o_emit = 1'b1;
                        if (i_item.rx_byte == DUMMY_BYTE) begin
                            n_poll = '0;
                            if (r_phase == PH_READY1) begin
                                n_phase = PH_READY2;
                            end else begin
                                fbyte            = frame_byte(3'd0, r_prefix, r_held_idx,
                                                              r_held_arg, 7'd0);
                                n_fidx           = '0;
                                n_crc            = crc7_byte(7'd0, fbyte);
                                n_phase          = PH_FRAME;
                                o_result.tx_byte = fbyte;
                            end
                        end else begin
                            n_poll = poll_inc;
                            if (poll_inc >= ready_lim) begin
                                if (r_phase == PH_READY1) begin
                                    n_phase              = PH_FAILDESEL;
                                    o_result.card_select = 1'b0;
                                end else begin
                                    n_phase  = PH_IDLE;
                                    o_result = '{kind: KIND_DONE, tx_byte: 8'h00,
                                                 card_select: 1'b1, response: DUMMY_BYTE,
                                                 status: ST_NOT_READY};
                                end
                            end
                        end
                    end
                    PH_FAILDESEL: begin
                        n_phase  = PH_IDLE;
                        o_emit   = 1'b1;
                        o_result = '{kind: KIND_DONE, tx_byte: 8'h00, card_select: 1'b0,
                                     response: DUMMY_BYTE, status: ST_NOT_READY};
                    end
                    PH_FRAME: begin
                        o_emit = 1'b1;
                        if (r_fidx < CRC_POS) begin
                            fbyte            = frame_byte(next_pos, r_prefix, r_held_idx,
                                                          r_held_arg, r_crc);
                            n_fidx           = next_pos;
                            o_result.tx_byte = fbyte;
                            if (next_pos < CRC_POS) begin
                                n_crc = crc7_byte(r_crc, fbyte);
                            end
                        end else begin
                            n_poll = '0;
                            priority if (r_prefix) begin
                                n_phase = PH_APPRESP;
                            end else if (r_held_idx == STOP_CMD_INDEX) begin
                                n_phase = PH_STUFF;
                            end else begin
                                n_phase = PH_RESP;
                            end
                        end
                    end
                    PH_APPRESP: begin
                        o_emit = 1'b1;
                        if (i_item.rx_byte[7]) begin
                            n_poll = poll_inc;
                        end
                        if (!i_item.rx_byte[7] || poll_inc >= app_lim) begin
                            if (i_item.rx_byte > 8'd1) begin
                                n_held_arg           = {24'd0, i_item.rx_byte};
                                n_phase              = PH_APPDESEL;
                                o_result.card_select = 1'b0;
                            end else begin
                                // prefix accepted: send the real command frame
                                fbyte            = frame_byte(3'd0, 1'b0, r_held_idx,
                                                              r_held_arg, 7'd0);
                                n_prefix         = 1'b0;
                                n_fidx           = '0;
                                n_crc            = crc7_byte(7'd0, fbyte);
                                n_phase          = PH_FRAME;
                                o_result.tx_byte = fbyte;
                            end
                        end
                    end
                    PH_APPDESEL: begin
                        n_phase  = PH_IDLE;
                        o_emit   = 1'b1;
                        o_result = '{kind: KIND_DONE, tx_byte: 8'h00, card_select: 1'b0,
                                     response: r_held_arg[7:0], status: ST_PREFIX_REJECTED};
                    end
                    PH_STUFF: begin
                        n_poll  = '0;
                        n_phase = PH_RESP;
                        o_emit  = 1'b1;
                    end
                    PH_RESP: begin
                        o_emit = 1'b1;
                        if (!i_item.rx_byte[7]) begin
                            n_phase  = PH_IDLE;
                            o_result = '{kind: KIND_DONE, tx_byte: 8'h00, card_select: 1'b1,
                                         response: i_item.rx_byte, status: ST_OK};
                        end else begin
                            n_poll = poll_inc;
                            if (poll_inc >= resp_lim) begin
                                n_phase  = PH_IDLE;
                                o_result = '{kind: KIND_DONE, tx_byte: 8'h00,
                                             card_select: 1'b1, response: i_item.rx_byte,
                                             status: ST_NO_RESPONSE};
                            end
                        end
                    end
                    default: begin
                        // received byte while idle: drop it
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    a_start_to_desel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.command == CMD_START |=> r_phase == PH_DESEL)
        else $error("start item did not enter the deselect phase");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_emit && o_result.kind == KIND_DONE |=> r_phase == PH_IDLE)
        else $error("finished command left the sequencer busy");

    a_busy_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_phase != PH_IDLE |-> o_emit)
        else $error("busy sequencer swallowed an item");

    a_fidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fidx <= CRC_POS)
        else $error("frame position ran past the CRC byte");

endmodule

// ----- rtl/core/sd_spi_command_engine.sv -----
// Top level of the SD SPI command engine: stream ports, config registers, item staging.
//
//  channel   direction  handshake                      payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready tuser command, tdata fields
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready tuser kind, tdata fields
//  cfg       in         i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
// One item per cycle sustained while results are taken; an accepted item is registered,
// worked combinationally by the sequencer, and any result it yields lands in the output register.
// A stalled output register holds its result while the input register still takes
// one more item; ready drops only when both are full and the output is not taken.
// Synchronous active-low reset clears control state and loads the default limits.
// Config writes are always accepted.
module sd_spi_command_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [5:0] cmd_index, [6] app_command, [38:7] argument, [46:39] rx_byte, [47] zero
    input  logic [47:0] i_s_axis_tdata,
    // [0] command
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] tx_byte, [8] card_select, [16:9] response, [18:17] status, [23:19] zero
    output logic [23:0] o_m_axis_tdata,
    // [0] kind
    output logic        o_m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);
    import sdce_pkg::*;

    logic    r_in_vld, n_in_vld;
    t_item   r_in;
    logic    r_out_vld, n_out_vld;
    t_result r_out;
    t_cfg    r_cfg;

    logic    out_free;
    logic    fire;
    logic    emit;
    t_result result;

    assign out_free        = !r_out_vld || i_m_axis_tready;
    assign fire            = r_in_vld && out_free;
    assign o_s_axis_tready = !r_in_vld || out_free;
    assign o_cfg_ready     = 1'b1;

    assign n_in_vld  = (i_s_axis_tvalid && o_s_axis_tready) ? 1'b1 : (fire ? 1'b0 : r_in_vld);
    assign n_out_vld = (fire && emit) ? 1'b1 : (i_m_axis_tready ? 1'b0 : r_out_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cfg     <= '{ready_poll_limit: READY_LIMIT_RST,
                           response_poll_limit: RESP_LIMIT_RST,
                           app_response_limit: APP_LIMIT_RST};
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_READY_LIMIT: r_cfg.ready_poll_limit    <= i_cfg_data;
                    REG_RESP_LIMIT:  r_cfg.response_poll_limit <= i_cfg_data[7:0];
                    REG_APP_LIMIT:   r_cfg.app_response_limit  <= i_cfg_data[7:0];
                    default: begin
                        // unknown index: drop the write
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in <= '{command: i_s_axis_tuser,
                      cmd_index: i_s_axis_tdata[5:0],
                      app_command: i_s_axis_tdata[6],
                      argument: i_s_axis_tdata[38:7],
                      rx_byte: i_s_axis_tdata[46:39]};
        end
        if (fire && emit) begin
            r_out <= result;
        end
    end

    sdce_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_emit   (emit),
        .o_result (result)
    );

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tdata  = {5'd0, r_out.status, r_out.response, r_out.card_select,
                              r_out.tx_byte};

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_m_axis_tready |-> !fire)
        else $error("stalled result would be overwritten");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_in_vld)
        else $error("accepted item not held in the input register");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && emit |=> o_m_axis_tvalid)
        else $error("result produced but not presented");

endmodule
